FILE: sv/ssd_pkg.sv
// ---------------------------------------------------------------------------
// ssd_pkg
// Shared constants for the segment-to-segment squared distance pipeline.
// ---------------------------------------------------------------------------
package ssd_pkg;

   // default coordinate width (signed Q8.8)
   localparam int COORD_BITS_DEF = 16;
   // default fraction width of the segment parameters sc and tc
   localparam int FRAC_BITS_DEF  = 24;
   // near-zero threshold register width
   localparam int EPS_BITS       = 16;
   // result width (unsigned Q20.16) and saturation value
   localparam int DIST_BITS      = 36;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

endpackage

FILE: sv/segment_segment_distance_sq_top.sv
// ---------------------------------------------------------------------------
// segment_segment_distance_sq_top
// Squared closest distance between two 3D segments, fully pipelined.
// ---------------------------------------------------------------------------
// The block takes one segment pair per clock unless the pipeline is full
// and the output stalled, and presents its squared closest distance
// (Q20.16, saturated) from the output register of the last stage. The two
// dividers that form sc and tc resolve one quotient bit per pipeline stage.
// Each stage holds its beat when the stage ahead is full and stalled, so
// bubbles collapse and the input keeps taking beats while a result waits,
// until every stage holds a beat.
// csr_wr_data sets the near-zero threshold; write it only while idle.
module segment_segment_distance_sq_top #(
   parameter int COORD_BITS      = ssd_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = ssd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ssd_pkg::EPS_BITS-1:0]        csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_BITS-1:0]        req_a_start_x,
   input  logic signed [COORD_BITS-1:0]        req_a_start_y,
   input  logic signed [COORD_BITS-1:0]        req_a_start_z,
   input  logic signed [COORD_BITS-1:0]        req_a_end_x,
   input  logic signed [COORD_BITS-1:0]        req_a_end_y,
   input  logic signed [COORD_BITS-1:0]        req_a_end_z,
   input  logic signed [COORD_BITS-1:0]        req_b_start_x,
   input  logic signed [COORD_BITS-1:0]        req_b_start_y,
   input  logic signed [COORD_BITS-1:0]        req_b_start_z,
   input  logic signed [COORD_BITS-1:0]        req_b_end_x,
   input  logic signed [COORD_BITS-1:0]        req_b_end_y,
   input  logic signed [COORD_BITS-1:0]        req_b_end_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ssd_pkg::DIST_BITS-1:0]       rsp_dist_sq
);

   localparam int FB   = PARAM_FRAC_BITS;
   localparam int DW   = COORD_BITS + 1;      // difference vectors
   localparam int DOTW = 2 * DW + 2;          // dot products a..e
   localparam int PRW  = 2 * DOTW;            // products of dot products
   localparam int NW   = PRW + 1;             // D, sN, tN and denominators
   localparam int QW   = FB + 1;              // sc, tc up to 1.0
   localparam int PW   = QW + 1 + DW;         // sc*u, tc*v
   localparam int DPW  = DW + 3;              // rounded difference component
   localparam int TW   = FB + DPW;            // unrounded component
   localparam int SQW  = 2 * DPW;
   localparam int SUMW = SQW + 2;
   localparam int OW   = ssd_pkg::DIST_BITS;
   localparam int CMPW = (SUMW > OW) ? SUMW : OW + 1;
   localparam int GW   = 9 * DW;
   localparam int ST_DIV = 6;                 // divider setup stage
   localparam int ST_F   = ST_DIV + FB + 1;   // first stage after divider
   localparam int NST    = ST_F + 4;
   localparam logic signed [TW-1:0] HALF = TW'(1) <<< (FB - 1);
   localparam logic [QW-1:0]        ONE  = QW'(1) << FB;

   // value x counts as zero when -eps <= x <= eps
   function automatic logic near_zero(input logic signed [NW-1:0] x,
                                      input logic [ssd_pkg::EPS_BITS-1:0] eps);
      logic signed [NW-1:0] pe;
      pe = NW'(eps);
      return (x <= pe) && (x >= -pe);
   endfunction

   // three-term dot product
   function automatic logic signed [DOTW-1:0] dot3(
      input logic signed [DW-1:0] x0, input logic signed [DW-1:0] x1,
      input logic signed [DW-1:0] x2, input logic signed [DW-1:0] y0,
      input logic signed [DW-1:0] y1, input logic signed [DW-1:0] y2);
      logic signed [DOTW-1:0] s;
      s = DOTW'(x0 * y0) + DOTW'(x1 * y1) + DOTW'(x2 * y2);
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Handshake: each stage advances when empty or when the next advances
   // ------------------------------------------------------------------
   logic [NST-1:0] v_ff, v_in, en;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_ready;
      for (int i = NST - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NST; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NST-1];

   // ------------------------------------------------------------------
   // Threshold register
   // ------------------------------------------------------------------
   logic [ssd_pkg::EPS_BITS-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= '0;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: u = A end - A start, v = B end - B start, w = A start - B start
   // Vectors travel packed as {w, v, u}, three components each.
   // ------------------------------------------------------------------
   logic [GW-1:0] g_ff [ST_F];
   logic [GW-1:0] g0_in;
   logic signed [DW-1:0] d_ux, d_uy, d_uz, d_vx, d_vy, d_vz, d_wx, d_wy, d_wz;

   always_comb begin
      d_ux = DW'(req_a_end_x) - DW'(req_a_start_x);
      d_uy = DW'(req_a_end_y) - DW'(req_a_start_y);
      d_uz = DW'(req_a_end_z) - DW'(req_a_start_z);
      d_vx = DW'(req_b_end_x) - DW'(req_b_start_x);
      d_vy = DW'(req_b_end_y) - DW'(req_b_start_y);
      d_vz = DW'(req_b_end_z) - DW'(req_b_start_z);
      d_wx = DW'(req_a_start_x) - DW'(req_b_start_x);
      d_wy = DW'(req_a_start_y) - DW'(req_b_start_y);
      d_wz = DW'(req_a_start_z) - DW'(req_b_start_z);
      g0_in = {d_wz, d_wy, d_wx, d_vz, d_vy, d_vx, d_uz, d_uy, d_ux};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         g_ff[0] <= g0_in;
      end
   end

   // carry the vectors down to the final stages
   for (genvar gi = 1; gi < ST_F; gi++) begin : g_carry
      always_ff @(posedge clock) begin
         if (en[gi]) begin
            g_ff[gi] <= g_ff[gi-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: dot products
   // ------------------------------------------------------------------
   logic signed [DOTW-1:0] a1_ff, b1_ff, c1_ff, d1_ff, e1_ff;
   logic signed [DW-1:0]   s1u [3];
   logic signed [DW-1:0]   s1v [3];
   logic signed [DW-1:0]   s1w [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1u[k] = g_ff[0][k*DW +: DW];
         s1v[k] = g_ff[0][(3+k)*DW +: DW];
         s1w[k] = g_ff[0][(6+k)*DW +: DW];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         a1_ff <= dot3(s1u[0], s1u[1], s1u[2], s1u[0], s1u[1], s1u[2]);
         b1_ff <= dot3(s1u[0], s1u[1], s1u[2], s1v[0], s1v[1], s1v[2]);
         c1_ff <= dot3(s1v[0], s1v[1], s1v[2], s1v[0], s1v[1], s1v[2]);
         d1_ff <= dot3(s1u[0], s1u[1], s1u[2], s1w[0], s1w[1], s1w[2]);
         e1_ff <= dot3(s1v[0], s1v[1], s1v[2], s1w[0], s1w[1], s1w[2]);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: the six products of dot products
   // ------------------------------------------------------------------
   logic signed [PRW-1:0]  ac2_ff, bb2_ff, be2_ff, cd2_ff, ae2_ff, bd2_ff;
   logic signed [DOTW-1:0] a2_ff, b2_ff, c2_ff, d2_ff, e2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ac2_ff <= PRW'(a1_ff) * PRW'(c1_ff);
         bb2_ff <= PRW'(b1_ff) * PRW'(b1_ff);
         be2_ff <= PRW'(b1_ff) * PRW'(e1_ff);
         cd2_ff <= PRW'(c1_ff) * PRW'(d1_ff);
         ae2_ff <= PRW'(a1_ff) * PRW'(e1_ff);
         bd2_ff <= PRW'(b1_ff) * PRW'(d1_ff);
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         d2_ff  <= d1_ff;
         e2_ff  <= e1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: denominator D and raw numerators
   // ------------------------------------------------------------------
   logic signed [NW-1:0]   dd3_ff, sn3_ff, tn3_ff;
   logic signed [DOTW-1:0] a3_ff, b3_ff, c3_ff, d3_ff, e3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dd3_ff <= NW'(ac2_ff) - NW'(bb2_ff);
         sn3_ff <= NW'(be2_ff) - NW'(cd2_ff);
         tn3_ff <= NW'(ae2_ff) - NW'(bd2_ff);
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         c3_ff  <= c2_ff;
         d3_ff  <= d2_ff;
         e3_ff  <= e2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: parallel case and clamp of sN to the edges of A
   // ------------------------------------------------------------------
   logic signed [NW-1:0]   sn4_in, sd4_in, tn4_in, td4_in;
   logic signed [NW-1:0]   sn4_ff, sd4_ff, tn4_ff, td4_ff;
   logic signed [DOTW-1:0] a4_ff, b4_ff, d4_ff;

   always_comb begin
      priority if (near_zero(dd3_ff, eps_ff)) begin
         sn4_in = '0;
         sd4_in = NW'(1);
         tn4_in = NW'(e3_ff);
         td4_in = NW'(c3_ff);
      end else if (sn3_ff < 0) begin
         sn4_in = '0;
         sd4_in = dd3_ff;
         tn4_in = NW'(e3_ff);
         td4_in = NW'(c3_ff);
      end else if (sn3_ff > dd3_ff) begin
         sn4_in = dd3_ff;
         sd4_in = dd3_ff;
         tn4_in = NW'(e3_ff) + NW'(b3_ff);
         td4_in = NW'(c3_ff);
      end else begin
         sn4_in = sn3_ff;
         sd4_in = dd3_ff;
         tn4_in = tn3_ff;
         td4_in = dd3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         sn4_ff <= sn4_in;
         sd4_ff <= sd4_in;
         tn4_ff <= tn4_in;
         td4_ff <= td4_in;
         a4_ff  <= a3_ff;
         b4_ff  <= b3_ff;
         d4_ff  <= d3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: clamp tN to the edges of B, recompute sN
   // ------------------------------------------------------------------
   logic signed [NW-1:0] sn5_in, sd5_in, tn5_in;
   logic signed [NW-1:0] sn5_ff, sd5_ff, tn5_ff, td5_ff;
   logic signed [NW-1:0] nd5, bmd5, aw5;

   always_comb begin
      nd5    = -NW'(d4_ff);
      bmd5   = NW'(b4_ff) - NW'(d4_ff);
      aw5    = NW'(a4_ff);
      sn5_in = sn4_ff;
      sd5_in = sd4_ff;
      tn5_in = tn4_ff;
      priority if (tn4_ff < 0) begin
         tn5_in = '0;
         priority if (nd5 < 0) begin
            sn5_in = '0;
         end else if (nd5 > aw5) begin
            sn5_in = sd4_ff;
         end else begin
            sn5_in = nd5;
            sd5_in = aw5;
         end
      end else if (tn4_ff > td4_ff) begin
         tn5_in = td4_ff;
         priority if (bmd5 < 0) begin
            sn5_in = '0;
         end else if (bmd5 > aw5) begin
            sn5_in = sd4_ff;
         end else begin
            sn5_in = bmd5;
            sd5_in = aw5;
         end
      end else begin
         tn5_in = tn4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         sn5_ff <= sn5_in;
         sd5_ff <= sd5_in;
         tn5_ff <= tn5_in;
         td5_ff <= td4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stages 6 .. 6+FB: two restoring dividers, one quotient bit a stage.
   // Index 0 is the setup stage; it flags the zero and one cases.
   // ------------------------------------------------------------------
   logic [NW-1:0] srem_ff [FB+1];
   logic [NW-1:0] sden_ff [FB+1];
   logic [FB-1:0] sq_ff   [FB+1];
   logic          sz_ff   [FB+1];
   logic          so_ff   [FB+1];
   logic [NW-1:0] trem_ff [FB+1];
   logic [NW-1:0] tden_ff [FB+1];
   logic [FB-1:0] tq_ff   [FB+1];
   logic          tz_ff   [FB+1];
   logic          to_ff   [FB+1];

   always_ff @(posedge clock) begin
      if (en[ST_DIV]) begin
         srem_ff[0] <= sn5_ff;
         sden_ff[0] <= sd5_ff;
         sq_ff[0]   <= '0;
         sz_ff[0]   <= near_zero(sn5_ff, eps_ff) || (sd5_ff <= 0) || (sn5_ff <= 0);
         so_ff[0]   <= sn5_ff >= sd5_ff;
         trem_ff[0] <= tn5_ff;
         tden_ff[0] <= td5_ff;
         tq_ff[0]   <= '0;
         tz_ff[0]   <= near_zero(tn5_ff, eps_ff) || (td5_ff <= 0) || (tn5_ff <= 0);
         to_ff[0]   <= tn5_ff >= td5_ff;
      end
   end

   for (genvar gj = 1; gj <= FB; gj++) begin : g_div
      logic [NW:0] s_sh, t_sh;
      logic        s_ge, t_ge;

      always_comb begin
         s_sh = {srem_ff[gj-1], 1'b0};
         t_sh = {trem_ff[gj-1], 1'b0};
         s_ge = s_sh >= {1'b0, sden_ff[gj-1]};
         t_ge = t_sh >= {1'b0, tden_ff[gj-1]};
      end

      always_ff @(posedge clock) begin
         if (en[ST_DIV+gj]) begin
            srem_ff[gj] <= s_ge ? NW'(s_sh - {1'b0, sden_ff[gj-1]}) : NW'(s_sh);
            sden_ff[gj] <= sden_ff[gj-1];
            sq_ff[gj]   <= {sq_ff[gj-1][FB-2:0], s_ge};
            sz_ff[gj]   <= sz_ff[gj-1];
            so_ff[gj]   <= so_ff[gj-1];
            trem_ff[gj] <= t_ge ? NW'(t_sh - {1'b0, tden_ff[gj-1]}) : NW'(t_sh);
            tden_ff[gj] <= tden_ff[gj-1];
            tq_ff[gj]   <= {tq_ff[gj-1][FB-2:0], t_ge};
            tz_ff[gj]   <= tz_ff[gj-1];
            to_ff[gj]   <= to_ff[gj-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage ST_F: scale u and v by sc and tc
   // ------------------------------------------------------------------
   logic [QW-1:0]        sc_f, tc_f;
   logic signed [DW-1:0] fu [3];
   logic signed [DW-1:0] fv [3];
   logic signed [DW-1:0] fw [3];
   logic signed [PW-1:0] psu_ff [3];
   logic signed [PW-1:0] ptv_ff [3];
   logic signed [DW-1:0] w6_ff  [3];

   always_comb begin
      sc_f = sz_ff[FB] ? '0 : (so_ff[FB] ? ONE : {1'b0, sq_ff[FB]});
      tc_f = tz_ff[FB] ? '0 : (to_ff[FB] ? ONE : {1'b0, tq_ff[FB]});
      for (int k = 0; k < 3; k++) begin
         fu[k] = g_ff[ST_F-1][k*DW +: DW];
         fv[k] = g_ff[ST_F-1][(3+k)*DW +: DW];
         fw[k] = g_ff[ST_F-1][(6+k)*DW +: DW];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_F]) begin
         for (int k = 0; k < 3; k++) begin
            psu_ff[k] <= $signed({1'b0, sc_f}) * fu[k];
            ptv_ff[k] <= $signed({1'b0, tc_f}) * fv[k];
            w6_ff[k]  <= fw[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage ST_F+1: sum and round each component to nearest
   // ------------------------------------------------------------------
   logic signed [TW-1:0]  t_f [3];
   logic signed [DPW-1:0] dp_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t_f[k] = (TW'(w6_ff[k]) <<< FB) + TW'(psu_ff[k]) - TW'(ptv_ff[k]) + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_F+1]) begin
         for (int k = 0; k < 3; k++) begin
            dp_ff[k] <= DPW'(t_f[k] >>> FB);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage ST_F+2: square components
   // ------------------------------------------------------------------
   logic [SQW-1:0] sq2_ff [3];

   always_ff @(posedge clock) begin
      if (en[ST_F+2]) begin
         for (int k = 0; k < 3; k++) begin
            sq2_ff[k] <= SQW'(dp_ff[k] * dp_ff[k]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage ST_F+3: add and saturate into the output register
   // ------------------------------------------------------------------
   logic [CMPW-1:0] sum_f;
   logic [OW-1:0]   dist_in, dist_ff;

   always_comb begin
      sum_f   = CMPW'(SUMW'(sq2_ff[0]) + SUMW'(sq2_ff[1]) + SUMW'(sq2_ff[2]));
      dist_in = (sum_f > CMPW'(ssd_pkg::DIST_MAX)) ? ssd_pkg::DIST_MAX : sum_f[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[ST_F+3]) begin
         dist_ff <= dist_in;
      end
   end

   assign rsp_dist_sq = dist_ff;

endmodule
